### hdl/pvam_pkg.sv
`default_nettype none
package pvam_pkg;

  localparam int unsigned NUM_VOICES = 8;
  localparam int unsigned VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam int unsigned LVL_W = 25;
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned IDX_OUT_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0] FULL_SCALE    = LVL_W'(25'h100_0000);
  localparam logic [LVL_W-1:0] END_THRESHOLD = LVL_W'(1677);

  localparam logic [LVL_W-1:0] ATTACK_RESET  = LVL_W'(19418);
  localparam logic [LVL_W-1:0] DECAY_RESET   = LVL_W'(1942);
  localparam logic [LVL_W-1:0] SUSTAIN_RESET = LVL_W'(12079596);
  localparam logic [LVL_W-1:0] RELEASE_RESET = LVL_W'(1248);

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_TICK     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [LVL_W-1:0]  level;
    logic [LVL_W-1:0]  rel_start;
    logic              released;
    logic              decaying;
  } voice_entry_t;

  // Keep a rate within 1 .. full scale.
  function automatic logic [LVL_W-1:0] clamp_rate(input logic [LVL_W-1:0] r);
    logic [LVL_W-1:0] res;
    res = r;
    if (r == '0) begin
      res = LVL_W'(1);
    end else if (r > FULL_SCALE) begin
      res = FULL_SCALE;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hdl/poly_voice_adsr_manager_unit.sv
`default_nettype none
// Channel | direction | handshake             | payload
// --------+-----------+-----------------------+---------------------------------------------
// in      | input     | in_valid_i / in_stall_o | op_i, note_i, velocity_i
// out     | output    | out_valid_o / out_stall_i | voice_index_o, voice_on_o, voice_note_o,
//         |           |                       | level_o, voice_velocity_o, last_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Note-on and all-notes-off are handled at the transfer, in the idle state. Note-off does one
// read-modify-write per voice through the single voice memory port pair.
// Tick reads and multiplies, then updates and writes back, for each voice in turn,
// and holds while the output side stalls.
// Reset clears the active marks, round-robin pointer and registers; the voice memory is not
// cleared, since an entry's contents are only used while its active mark says note-on wrote it.
// A result waits in the output register while the next voice is read and multiplied.
module poly_voice_adsr_manager_unit
  import pvam_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input items
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [NOTE_W-1:0]    note_i,
  input  wire logic [VEL_W-1:0]     velocity_i,
  // results
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [IDX_OUT_W-1:0]      voice_index_o,
  output logic                      voice_on_o,
  output logic [NOTE_W-1:0]         voice_note_o,
  output logic [LVL_W-1:0]          level_o,
  output logic [VEL_W-1:0]          voice_velocity_o,
  output logic                      last_o,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LVL_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFF_WR,
    ST_TK_MUL,
    ST_TK_UPD
  } state_e;

  state_e state_q;

  // configuration registers
  logic [LVL_W-1:0] attack_q, decay_q, sustain_q, release_q;

  // per-voice active marks in flops, the rest of the voice state in memory
  logic [NUM_VOICES-1:0] active_q;
  logic [VIDX_W-1:0]     next_slot_q;
  logic [VIDX_W-1:0]     cnt_q;
  logic [LVL_W-1:0]      prod_q;
  // note of the note-off being walked; the input side moves on after the transfer
  logic [NOTE_W-1:0]     off_note_q;

  voice_entry_t voice_mem_q [NUM_VOICES];
  voice_entry_t rd_data_q;

  logic              mem_we;
  logic [VIDX_W-1:0] mem_wa;
  voice_entry_t      mem_wd;
  logic              mem_re;
  logic [VIDX_W-1:0] mem_ra;

  // output register
  logic                 out_valid_q;
  logic [IDX_OUT_W-1:0] out_idx_q;
  logic                 out_on_q;
  logic [NOTE_W-1:0]    out_note_q;
  logic [LVL_W-1:0]     out_level_q;
  logic [VEL_W-1:0]     out_vel_q;
  logic                 out_last_q;

  logic in_xfer;
  op_e  op;
  logic cnt_last;
  logic out_load;
  logic cur_active;

  logic [LVL_W-1:0]   ar_c, dr_c, rr_c, sus_c;
  logic [LVL_W-1:0]   mul_a, mul_b;
  logic [2*LVL_W-1:0] prod;

  logic [LVL_W-1:0] lvl;
  logic [LVL_W:0]   att_sum;
  logic [LVL_W-1:0] lvl_new;
  logic             rel_end;
  voice_entry_t     tk_entry;
  voice_entry_t     off_entry;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign op          = op_e'(op_i);
  assign cfg_ready_o = 1'b1;
  assign cnt_last    = (cnt_q == VIDX_W'(NUM_VOICES - 1));
  assign cur_active  = active_q[cnt_q];
  assign out_load    = (state_q == ST_TK_UPD) && (!out_valid_q || !out_stall_i);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RESET;
      decay_q   <= DECAY_RESET;
      sustain_q <= SUSTAIN_RESET;
      release_q <= RELEASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ATTACK:  attack_q  <= cfg_data_i;
        REG_DECAY:   decay_q   <= cfg_data_i;
        REG_SUSTAIN: sustain_q <= cfg_data_i;
        REG_RELEASE: release_q <= cfg_data_i;
        default:     attack_q  <= attack_q;
      endcase
    end
  end

  assign ar_c  = clamp_rate(attack_q);
  assign dr_c  = clamp_rate(decay_q);
  assign rr_c  = clamp_rate(release_q);
  assign sus_c = (sustain_q > FULL_SCALE) ? FULL_SCALE : sustain_q;

  // One shared multiplier: release step from the start level, or decay step from the span
  // above sustain. Registered before the update stage.
  assign mul_a = rd_data_q.released ? rd_data_q.rel_start : (FULL_SCALE - sus_c);
  assign mul_b = rd_data_q.released ? rr_c : dr_c;
  assign prod  = mul_a * mul_b;

  // Envelope update for the voice whose entry sits in the read register.
  assign lvl     = rd_data_q.level;
  assign att_sum = {1'b0, lvl} + {1'b0, ar_c};

  always_comb begin
    tk_entry = rd_data_q;
    lvl_new  = lvl;
    rel_end  = 1'b0;
    if (rd_data_q.released) begin
      lvl_new = (prod_q >= lvl) ? '0 : (lvl - prod_q);
      rel_end = (lvl_new <= END_THRESHOLD);
    end else if (!rd_data_q.decaying && (lvl < FULL_SCALE)) begin
      // attack: rise and saturate at full scale
      lvl_new = (att_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : att_sum[LVL_W-1:0];
    end else begin
      // decay toward sustain, never below it
      tk_entry.decaying = 1'b1;
      if (lvl > sus_c) begin
        lvl_new = ((lvl - sus_c) > prod_q) ? (lvl - prod_q) : sus_c;
      end
    end
    tk_entry.level = lvl_new;
  end

  // Note-off: release every matching, active, unreleased voice and remember its level.
  always_comb begin
    off_entry = rd_data_q;
    if (cur_active && !rd_data_q.released && (rd_data_q.note == off_note_q)) begin
      off_entry.released  = 1'b1;
      off_entry.rel_start = rd_data_q.level;
    end
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q;
    mem_wd = rd_data_q;
    mem_re = 1'b0;
    mem_ra = VIDX_W'(cnt_q + 1'b1);
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op == OP_NOTE_ON) begin
            mem_we             = 1'b1;
            mem_wa             = next_slot_q;
            mem_wd.note        = note_i;
            mem_wd.velocity    = velocity_i;
            mem_wd.level       = '0;
            mem_wd.rel_start   = '0;
            mem_wd.released    = 1'b0;
            mem_wd.decaying    = 1'b0;
          end else if (op == OP_NOTE_OFF || op == OP_TICK) begin
            mem_re = 1'b1;
            mem_ra = '0;
          end
        end
      end
      ST_OFF_WR: begin
        mem_we = 1'b1;
        mem_wd = off_entry;
        mem_re = !cnt_last;
      end
      ST_TK_UPD: begin
        if (out_load) begin
          mem_we = cur_active;
          mem_wd = tk_entry;
          mem_re = !cnt_last;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Voice memory: one write and one registered read per cycle, never the same entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      voice_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= voice_mem_q[mem_ra];
    end
  end

  // Sequencer, marks and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      next_slot_q <= '0;
      cnt_q       <= '0;
      prod_q      <= '0;
      off_note_q  <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_on_q    <= 1'b0;
      out_note_q  <= '0;
      out_level_q <= '0;
      out_vel_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // drop the result once transferred, unless a new one replaces it
      out_valid_q <= out_load || (out_valid_q && out_stall_i);

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (op)
              OP_NOTE_ON: begin
                active_q[next_slot_q] <= 1'b1;
                next_slot_q <= (next_slot_q == VIDX_W'(NUM_VOICES - 1)) ? '0
                             : VIDX_W'(next_slot_q + 1'b1);
              end
              OP_NOTE_OFF: begin
                cnt_q      <= '0;
                off_note_q <= note_i;
                state_q    <= ST_OFF_WR;
              end
              OP_ALL_OFF: begin
                active_q <= '0;
              end
              OP_TICK: begin
                cnt_q   <= '0;
                state_q <= ST_TK_MUL;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_OFF_WR: begin
          if (cnt_last) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= VIDX_W'(cnt_q + 1'b1);
          end
        end
        ST_TK_MUL: begin
          prod_q  <= prod[2*LVL_W-2:LVL_W-1];
          state_q <= ST_TK_UPD;
        end
        ST_TK_UPD: begin
          // hold here while the previous result still waits
          if (out_load) begin
            out_idx_q  <= IDX_OUT_W'(cnt_q);
            out_last_q <= cnt_last;
            if (cur_active && !rel_end) begin
              out_on_q    <= 1'b1;
              out_note_q  <= rd_data_q.note;
              out_level_q <= lvl_new;
              out_vel_q   <= rd_data_q.velocity;
            end else begin
              out_on_q    <= 1'b0;
              out_note_q  <= '0;
              out_level_q <= '0;
              out_vel_q   <= '0;
            end
            if (cur_active && rel_end) begin
              active_q[cnt_q] <= 1'b0;
            end
            if (cnt_last) begin
              state_q <= ST_IDLE;
            end else begin
              cnt_q   <= VIDX_W'(cnt_q + 1'b1);
              state_q <= ST_TK_MUL;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign voice_index_o    = out_idx_q;
  assign voice_on_o       = out_on_q;
  assign voice_note_o     = out_note_q;
  assign level_o          = out_level_q;
  assign voice_velocity_o = out_vel_q;
  assign last_o           = out_last_q;

endmodule
`default_nettype wire
